// File: rtl/csbs_pkg.sv
`default_nettype none
package csbs_pkg;

  localparam int MAX_CHANNELS = 64;

  localparam int SCORE_W  = 12;
  localparam int COUNT_W  = 7;
  localparam int CHAN_W   = 8;
  localparam int FREQ_W   = 16;
  localparam int TIME_W   = 40;
  localparam int NOISE_W  = 8;
  localparam int BAND_W   = 2;

  // quotient bits: eight for the percentage plus one overflow bit
  localparam int DIV_STEPS = 9;
  localparam int DIV_IDX_W = 4;
  localparam int DIVD_W    = TIME_W + 7;
  localparam int DSOR_W    = TIME_W + DIV_STEPS - 1;

  localparam logic [BAND_W-1:0] BAND_2G4 = 2'd0;
  localparam logic [BAND_W-1:0] BAND_5G  = 2'd1;
  localparam logic [BAND_W-1:0] BAND_6G  = 2'd2;

  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  localparam int SCORE_BASE   = 1000;
  localparam int BONUS_5G     = 100;
  localparam int BONUS_6G     = 200;
  localparam int WIDE_BONUS   = 50;
  localparam int RADAR_COST   = 50;
  localparam int NOISE_REF    = 100;
  localparam int CHAN_2G4_MAX = 13;

  typedef struct packed {
    logic                 load;
    logic                 mul;
    logic                 div_step;
    logic [DIV_IDX_W-1:0] div_idx;
    logic                 score;
    logic                 update;
  } cmd_t;

endpackage
`default_nettype wire

// File: rtl/csbs_ctrl.sv
`default_nettype none
module csbs_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  wire logic         out_stall,
  output csbs_pkg::cmd_t    cmd
);
  import csbs_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_SCORE = 3'd3;
  localparam logic [2:0] ST_UPD   = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [DIV_IDX_W-1:0] idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.div_idx   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        idx_nxt   = DIV_IDX_W'(DIV_STEPS - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        idx_nxt      = idx_r - 1'b1;
        if (idx_r == '0) begin
          state_nxt = ST_SCORE;
        end
      end
      ST_SCORE: begin
        cmd.score = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          cmd.update    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/csbs_dp.sv
`default_nettype none
module csbs_dp (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire csbs_pkg::cmd_t                        cmd,
  input  wire logic                                  in_round_start,
  input  wire logic                                  in_round_end,
  input  wire logic [csbs_pkg::BAND_W-1:0]           in_band,
  input  wire logic [csbs_pkg::CHAN_W-1:0]           in_channel_number,
  input  wire logic [csbs_pkg::FREQ_W-1:0]           in_chan_freq,
  input  wire logic                                  in_disabled,
  input  wire logic                                  in_radar,
  input  wire logic                                  in_no_forty,
  input  wire logic                                  in_has_survey,
  input  wire logic [csbs_pkg::TIME_W-1:0]           in_busy_time,
  input  wire logic [csbs_pkg::TIME_W-1:0]           in_active_time,
  input  wire logic signed [csbs_pkg::NOISE_W-1:0]   in_noise,
  output logic signed [csbs_pkg::SCORE_W-1:0]        out_channel_score,
  output logic                                       out_channel_counted,
  output logic [csbs_pkg::CHAN_W-1:0]                out_best_channel,
  output logic [csbs_pkg::FREQ_W-1:0]                out_best_freq,
  output logic signed [csbs_pkg::SCORE_W-1:0]        out_top_score,
  output logic [csbs_pkg::COUNT_W-1:0]               out_scored_count,
  output logic                                       out_round_done
);
  import csbs_pkg::*;

  // captured item
  logic                      start_r, end_r, dis_r, radar_r, nof_r, surv_r;
  logic [BAND_W-1:0]         band_r;
  logic [CHAN_W-1:0]         chnum_r;
  logic [FREQ_W-1:0]         freq_r;
  logic [TIME_W-1:0]         busy_r, active_r;
  logic signed [NOISE_W-1:0] noise_r;

  // divider
  logic [DIVD_W-1:0]         rem_r;
  logic [DIV_STEPS-1:0]      q_r;
  logic [DIVD_W-1:0]         dividend;
  logic [DSOR_W-1:0]         dsor_sh;
  logic [DSOR_W-1:0]         rem_ext;
  logic                      div_ge;

  // score
  logic signed [SCORE_W-1:0] score_r, score_nxt;
  logic [7:0]                pct;
  logic signed [NOISE_W+1:0] noise_off;
  logic [7:0]                off;
  logic                      wide;
  logic [10:0]               pos, neg;
  logic signed [SCORE_W:0]   score_full;

  // round state
  logic signed [SCORE_W-1:0] top_score_r;
  logic [CHAN_W-1:0]         best_chan_r;
  logic [FREQ_W-1:0]         best_freq_r;
  logic [COUNT_W-1:0]        count_r;

  logic signed [SCORE_W-1:0] eff_score, new_score;
  logic [CHAN_W-1:0]         eff_chan, new_chan;
  logic [FREQ_W-1:0]         eff_freq, new_freq;
  logic [COUNT_W-1:0]        eff_count, new_count;
  logic                      counted, better, any;

  // busy * 100 as shifted adds
  assign dividend = (DIVD_W'(busy_r) << 6) + (DIVD_W'(busy_r) << 5)
                  + (DIVD_W'(busy_r) << 2);
  assign dsor_sh  = DSOR_W'(active_r) << cmd.div_idx;
  assign rem_ext  = DSOR_W'(rem_r);
  assign div_ge   = rem_ext >= dsor_sh;

  always_comb begin
    if (!surv_r || active_r == '0) begin
      pct = '0;
    end else if (q_r[DIV_STEPS-1]) begin
      pct = 8'hFF;
    end else begin
      pct = q_r[7:0];
    end
    noise_off = (surv_r ? (NOISE_W+2)'(noise_r) : '0) + (NOISE_W+2)'(NOISE_REF);
    off       = noise_off[NOISE_W+1] ? 8'd0 : noise_off[7:0];
    case (band_r)
      BAND_2G4: wide = (chnum_r >= 8'd1) && (chnum_r <= 8'(CHAN_2G4_MAX));
      BAND_6G:  wide = 1'b1;
      default:  wide = !nof_r;
    endcase
    pos = 11'(SCORE_BASE) + (wide ? 11'(WIDE_BONUS) : 11'd0);
    case (band_r)
      BAND_5G: pos = pos + 11'(BONUS_5G);
      BAND_6G: pos = pos + 11'(BONUS_6G);
      default: pos = pos;
    endcase
    neg = {1'b0, pct, 2'b00} + {2'b00, off, 1'b0} + {3'b000, off}
        + (radar_r ? 11'(RADAR_COST) : 11'd0);
    score_full = $signed({2'b00, pos}) - $signed({2'b00, neg});
    score_nxt  = score_full[SCORE_W-1:0];
  end

  always_comb begin
    eff_score = start_r ? SCORE_MIN : top_score_r;
    eff_chan  = start_r ? '0 : best_chan_r;
    eff_freq  = start_r ? '0 : best_freq_r;
    eff_count = start_r ? '0 : count_r;
    counted   = !dis_r && (eff_count < COUNT_W'(MAX_CHANNELS));
    better    = counted && (score_r > eff_score);
    new_score = better ? score_r : eff_score;
    new_chan  = better ? chnum_r : eff_chan;
    new_freq  = better ? freq_r : eff_freq;
    new_count = counted ? eff_count + 1'b1 : eff_count;
    any       = (new_count != '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      start_r  <= in_round_start;
      end_r    <= in_round_end;
      band_r   <= in_band;
      chnum_r  <= in_channel_number;
      freq_r   <= in_chan_freq;
      dis_r    <= in_disabled;
      radar_r  <= in_radar;
      nof_r    <= in_no_forty;
      surv_r   <= in_has_survey;
      busy_r   <= in_busy_time;
      active_r <= in_active_time;
      noise_r  <= in_noise;
    end
    if (cmd.mul) begin
      rem_r <= dividend;
      q_r   <= '0;
    end
    if (cmd.div_step && div_ge) begin
      rem_r             <= DIVD_W'(rem_ext - dsor_sh);
      q_r[cmd.div_idx]  <= 1'b1;
    end
    if (cmd.score) begin
      score_r <= score_nxt;
    end
    if (cmd.update) begin
      out_channel_score   <= counted ? score_r : '0;
      out_channel_counted <= counted;
      out_best_channel    <= any ? new_chan : '0;
      out_best_freq       <= any ? new_freq : '0;
      out_top_score       <= any ? new_score : '0;
      out_scored_count    <= new_count;
      out_round_done      <= end_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_score_r <= SCORE_MIN;
      best_chan_r <= '0;
      best_freq_r <= '0;
      count_r     <= '0;
    end else if (cmd.update) begin
      if (end_r) begin
        top_score_r <= SCORE_MIN;
        best_chan_r <= '0;
        best_freq_r <= '0;
        count_r     <= '0;
      end else begin
        top_score_r <= new_score;
        best_chan_r <= new_chan;
        best_freq_r <= new_freq;
        count_r     <= new_count;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/channel_score_best_select.sv
// steps: load, multiply by 100, divide, score, then update and offer the result
// a new item is taken only after the last one's update; the 9-step restoring divider
//   (eight quotient bits plus overflow) forms the busy percentage
// the result register lets the next item start while a result waits
// reset: synchronous active low rst_n clears control and the best choice
`default_nettype none
module channel_score_best_select (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  in_round_start,
  input  wire logic                                  in_round_end,
  input  wire logic [csbs_pkg::BAND_W-1:0]           in_band,
  input  wire logic [csbs_pkg::CHAN_W-1:0]           in_channel_number,
  input  wire logic [csbs_pkg::FREQ_W-1:0]           in_chan_freq,
  input  wire logic                                  in_disabled,
  input  wire logic                                  in_radar,
  input  wire logic                                  in_no_forty,
  input  wire logic                                  in_has_survey,
  input  wire logic [csbs_pkg::TIME_W-1:0]           in_busy_time,
  input  wire logic [csbs_pkg::TIME_W-1:0]           in_active_time,
  input  wire logic signed [csbs_pkg::NOISE_W-1:0]   in_noise,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [csbs_pkg::SCORE_W-1:0]        out_channel_score,
  output logic                                       out_channel_counted,
  output logic [csbs_pkg::CHAN_W-1:0]                out_best_channel,
  output logic [csbs_pkg::FREQ_W-1:0]                out_best_freq,
  output logic signed [csbs_pkg::SCORE_W-1:0]        out_top_score,
  output logic [csbs_pkg::COUNT_W-1:0]               out_scored_count,
  output logic                                       out_round_done
);
  import csbs_pkg::*;

  cmd_t cmd;

  csbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  csbs_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_round_start      (in_round_start),
    .in_round_end        (in_round_end),
    .in_band             (in_band),
    .in_channel_number   (in_channel_number),
    .in_chan_freq        (in_chan_freq),
    .in_disabled         (in_disabled),
    .in_radar            (in_radar),
    .in_no_forty         (in_no_forty),
    .in_has_survey       (in_has_survey),
    .in_busy_time        (in_busy_time),
    .in_active_time      (in_active_time),
    .in_noise            (in_noise),
    .out_channel_score   (out_channel_score),
    .out_channel_counted (out_channel_counted),
    .out_best_channel    (out_best_channel),
    .out_best_freq       (out_best_freq),
    .out_top_score       (out_top_score),
    .out_scored_count    (out_scored_count),
    .out_round_done      (out_round_done)
  );

endmodule
`default_nettype wire

// File: tb/channel_score_best_select_test.sv
`default_nettype none
module channel_score_best_select_test;
  timeunit 1ns;
  timeprecision 1ps;

  import csbs_pkg::*;

  localparam logic [BAND_W-1:0] BAND_SPARE = 2'd3;
  localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};

  typedef struct {
    logic                      round_start;
    logic                      round_end;
    logic [BAND_W-1:0]         band;
    logic [CHAN_W-1:0]         channel_number;
    logic [FREQ_W-1:0]         chan_freq;
    logic                      disabled;
    logic                      radar;
    logic                      no_forty;
    logic                      has_survey;
    logic [TIME_W-1:0]         busy_time;
    logic [TIME_W-1:0]         active_time;
    logic signed [NOISE_W-1:0] noise;
  } survey_rec_t;

  typedef struct {
    logic signed [SCORE_W-1:0] channel_score;
    logic                      channel_counted;
    logic [CHAN_W-1:0]         best_channel;
    logic [FREQ_W-1:0]         best_freq;
    logic signed [SCORE_W-1:0] top_score;
    logic [COUNT_W-1:0]        scored_count;
    logic                      round_done;
  } pick_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_round_start = 1'b0;
  logic                      in_round_end = 1'b0;
  logic [BAND_W-1:0]         in_band = '0;
  logic [CHAN_W-1:0]         in_channel_number = '0;
  logic [FREQ_W-1:0]         in_chan_freq = '0;
  logic                      in_disabled = 1'b0;
  logic                      in_radar = 1'b0;
  logic                      in_no_forty = 1'b0;
  logic                      in_has_survey = 1'b0;
  logic [TIME_W-1:0]         in_busy_time = '0;
  logic [TIME_W-1:0]         in_active_time = '0;
  logic signed [NOISE_W-1:0] in_noise = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [SCORE_W-1:0] out_channel_score;
  logic                      out_channel_counted;
  logic [CHAN_W-1:0]         out_best_channel;
  logic [FREQ_W-1:0]         out_best_freq;
  logic signed [SCORE_W-1:0] out_top_score;
  logic [COUNT_W-1:0]        out_scored_count;
  logic                      out_round_done;

  channel_score_best_select u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_round_start      (in_round_start),
    .in_round_end        (in_round_end),
    .in_band             (in_band),
    .in_channel_number   (in_channel_number),
    .in_chan_freq        (in_chan_freq),
    .in_disabled         (in_disabled),
    .in_radar            (in_radar),
    .in_no_forty         (in_no_forty),
    .in_has_survey       (in_has_survey),
    .in_busy_time        (in_busy_time),
    .in_active_time      (in_active_time),
    .in_noise            (in_noise),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_channel_score   (out_channel_score),
    .out_channel_counted (out_channel_counted),
    .out_best_channel    (out_best_channel),
    .out_best_freq       (out_best_freq),
    .out_top_score       (out_top_score),
    .out_scored_count    (out_scored_count),
    .out_round_done      (out_round_done)
  );

  always #2 clk = ~clk;

  // best choice tracked by the predictor
  logic signed [SCORE_W-1:0] track_top_score = SCORE_MIN;
  logic [CHAN_W-1:0]         track_best_channel = '0;
  logic [FREQ_W-1:0]         track_best_freq = '0;
  logic [COUNT_W-1:0]        track_count = '0;

  pick_t expected_picks[$];
  pick_t got_pick;
  int    errors = 0;
  int    hold_left = 0;
  bit    idle_on = 1'b1;

  function automatic void clear_round();
    track_top_score    = SCORE_MIN;
    track_best_channel = '0;
    track_best_freq    = '0;
    track_count        = '0;
  endfunction

  function automatic pick_t predict_pick(input survey_rec_t r);
    pick_t             p;
    longint unsigned   busy;
    longint unsigned   active;
    longint unsigned   pct;
    int                noise_dbm;
    int                offset;
    int                score;
    bit                wide;
    if (r.round_start) clear_round();
    p.channel_score   = '0;
    p.channel_counted = 1'b0;
    if (!r.disabled && track_count < MAX_CHANNELS) begin
      pct       = 0;
      noise_dbm = 0;
      if (r.has_survey) begin
        noise_dbm = int'(r.noise);
        busy      = 64'(r.busy_time);
        active    = 64'(r.active_time);
        if (active != 0) pct = (busy * 100) / active;
        if (pct > 255) pct = 255;
      end
      offset = noise_dbm + NOISE_REF;
      if (offset < 0) offset = 0;
      score = SCORE_BASE - int'(pct) * 4 - offset * 3;
      if (r.band == BAND_6G) score += BONUS_6G;
      else if (r.band == BAND_5G) score += BONUS_5G;
      if (r.radar) score -= RADAR_COST;
      if (r.band == BAND_2G4) begin
        wide = r.channel_number >= 1 && r.channel_number <= CHAN_2G4_MAX;
      end else if (r.band == BAND_6G) begin
        wide = 1'b1;
      end else begin
        wide = !r.no_forty;
      end
      if (wide) score += WIDE_BONUS;
      p.channel_score   = score[SCORE_W-1:0];
      p.channel_counted = 1'b1;
      if (score > int'(track_top_score)) begin
        track_top_score    = score[SCORE_W-1:0];
        track_best_channel = r.channel_number;
        track_best_freq    = r.chan_freq;
      end
      track_count = track_count + 1'b1;
    end
    if (track_count > 0) begin
      p.best_channel = track_best_channel;
      p.best_freq    = track_best_freq;
      p.top_score    = track_top_score;
    end else begin
      p.best_channel = '0;
      p.best_freq    = '0;
      p.top_score    = '0;
    end
    p.scored_count = track_count;
    p.round_done   = r.round_end;
    if (r.round_end) clear_round();
    return p;
  endfunction

  function automatic survey_rec_t make_survey(input bit start, input bit last, input int band,
                                              input int chan, input int freq, input bit dis,
                                              input bit rad, input bit nf, input bit surv,
                                              input logic [TIME_W-1:0] busy,
                                              input logic [TIME_W-1:0] active, input int noise);
    survey_rec_t r;
    r.round_start    = start;
    r.round_end      = last;
    r.band           = band[BAND_W-1:0];
    r.channel_number = chan[CHAN_W-1:0];
    r.chan_freq      = freq[FREQ_W-1:0];
    r.disabled       = dis;
    r.radar          = rad;
    r.no_forty       = nf;
    r.has_survey     = surv;
    r.busy_time      = busy;
    r.active_time    = active;
    r.noise          = noise[NOISE_W-1:0];
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[TIME_W-1:0];
  endfunction

  function automatic survey_rec_t rand_survey();
    survey_rec_t     r;
    longint unsigned act;
    r.round_start    = 1'b0;
    r.round_end      = 1'b0;
    r.band           = BAND_W'($urandom_range(0, 3));
    r.channel_number = ($urandom_range(0, 1) == 0) ? CHAN_W'($urandom_range(0, 15))
                                                   : CHAN_W'($urandom);
    r.chan_freq      = FREQ_W'($urandom);
    r.disabled       = ($urandom_range(0, 7) == 0);
    r.radar          = 1'($urandom);
    r.no_forty       = 1'($urandom);
    r.has_survey     = ($urandom_range(0, 7) != 0);
    case ($urandom_range(0, 5))
      0: begin
        r.active_time = '0;
        r.busy_time   = rand_time();
      end
      1: begin
        r.active_time = rand_time();
        r.busy_time   = rand_time();
      end
      2: begin
        r.active_time = rand_time();
        act           = 64'(r.active_time);
        act           = (act * $urandom_range(0, 100)) / 100;
        r.busy_time   = act[TIME_W-1:0];
      end
      3: begin
        r.active_time = TIME_W'($urandom_range(1, 1000));
        r.busy_time   = TIME_W'($urandom_range(0, 1200));
      end
      4: begin
        r.active_time = TIME_W'($urandom_range(1, 255));
        r.busy_time   = rand_time();
      end
      default: begin
        r.active_time = rand_time();
        r.busy_time   = r.active_time;
      end
    endcase
    if ($urandom_range(0, 1) == 0) r.noise = NOISE_W'(int'($urandom_range(0, 40)) - 110);
    else r.noise = NOISE_W'($urandom);
    return r;
  endfunction

  task automatic send_survey(input survey_rec_t r);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_round_start    <= r.round_start;
    in_round_end      <= r.round_end;
    in_band           <= r.band;
    in_channel_number <= r.channel_number;
    in_chan_freq      <= r.chan_freq;
    in_disabled       <= r.disabled;
    in_radar          <= r.radar;
    in_no_forty       <= r.no_forty;
    in_has_survey     <= r.has_survey;
    in_busy_time      <= r.busy_time;
    in_active_time    <= r.active_time;
    in_noise          <= r.noise;
    do @(posedge clk); while (in_stall);
    expected_picks.push_back(predict_pick(r));
  endtask

  task automatic check_field(input string name, input logic signed [16:0] want,
                             input logic signed [16:0] got);
    if (got !== want) begin
      $error("%s: expected %0d actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_picks.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          got_pick = expected_picks.pop_front();
          check_field("channel_score", got_pick.channel_score, out_channel_score);
          check_field("channel_counted", got_pick.channel_counted, out_channel_counted);
          check_field("best_channel", got_pick.best_channel, out_best_channel);
          check_field("best_freq", got_pick.best_freq, out_best_freq);
          check_field("top_score", got_pick.top_score, out_top_score);
          check_field("scored_count", got_pick.scored_count, out_scored_count);
          check_field("round_done", got_pick.round_done, out_round_done);
        end
        hold_left = idle_on ? $urandom_range(0, 4) : 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic test_directed_cases();
    // ties go to the earliest channel
    send_survey(make_survey(1, 0, BAND_6G, 1, 5955, 0, 0, 0, 1, '0, TIME_MAX, -128));
    send_survey(make_survey(0, 0, BAND_6G, 5, 5975, 0, 0, 1, 1, '0, 1000, -100));
    send_survey(make_survey(0, 0, BAND_2G4, 13, 2472, 0, 0, 1, 1, 500, 1000, -100));
    send_survey(make_survey(0, 0, BAND_2G4, 14, 2484, 0, 1, 0, 1, 10, 1000, 127));
    // no survey data, counters ignored
    send_survey(make_survey(0, 0, BAND_2G4, 0, 0, 0, 0, 0, 0, TIME_MAX, 7, 127));
    // busy percentage saturates, noise below the offset floor
    send_survey(make_survey(0, 0, BAND_5G, 36, 5180, 0, 1, 0, 1, TIME_MAX, 1, -101));
    send_survey(make_survey(0, 0, BAND_5G, 255, 65535, 0, 0, 1, 1, 12345, '0, -99));
    send_survey(make_survey(0, 0, BAND_SPARE, 40, 5200, 0, 0, 0, 1, TIME_MAX, TIME_MAX, -90));
    send_survey(make_survey(0, 0, BAND_SPARE, 44, 5220, 0, 1, 1, 0, '0, '0, 0));
    send_survey(make_survey(0, 0, BAND_6G, 233, 7115, 1, 0, 0, 1, '0, 1000, -128));
    send_survey(make_survey(0, 1, BAND_2G4, 6, 2437, 0, 0, 0, 1, 1, 3, -60));
    // new round without round_start, then a restart mid round
    send_survey(make_survey(0, 0, BAND_5G, 149, 5745, 0, 0, 0, 1, 3, 4, -95));
    send_survey(make_survey(1, 0, BAND_2G4, 1, 2412, 0, 0, 0, 1, '0, 1, -100));
    send_survey(make_survey(0, 1, BAND_2G4, 2, 2417, 1, 0, 0, 1, '0, 1, -100));
    // empty round
    send_survey(make_survey(1, 0, BAND_6G, 37, 6135, 1, 0, 0, 1, '0, 1, -100));
    send_survey(make_survey(0, 1, BAND_5G, 52, 5260, 1, 1, 1, 0, TIME_MAX, '0, -1));
    // start and end on one channel
    send_survey(make_survey(1, 1, BAND_5G, 100, 5500, 0, 1, 1, 1, 77, 100, -80));
    send_survey(make_survey(0, 1, BAND_2G4, 11, 2462, 1, 0, 0, 1, '0, 1, -100));
  endtask

  task automatic test_drained_sender();
    survey_rec_t r;
    for (int k = 0; k < 6; k++) begin
      r = rand_survey();
      r.round_start = (k == 0);
      r.round_end   = (k == 5);
      send_survey(r);
      in_valid <= 1'b0;
      while (expected_picks.size() != 0) @(posedge clk);
    end
  endtask

  task automatic test_random_rounds(input int n_items);
    survey_rec_t r;
    int          sent;
    int          len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 14) == 0) ? $urandom_range(64, 72) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        r = rand_survey();
        r.round_start = (i == 0);
        r.round_end   = (i == len - 1);
        if (len >= 64) r.disabled = ($urandom_range(0, 31) == 0);
        if ($urandom_range(0, 9) == 0) r.round_start = 1'($urandom);
        if ($urandom_range(0, 9) == 0) r.round_end = 1'($urandom);
        send_survey(r);
        sent++;
      end
    end
  endtask

  task automatic test_full_rate_stream();
    idle_on = 1'b0;
    test_random_rounds(100);
    idle_on = 1'b1;
  endtask

  initial begin
    clear_round();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_drained_sender();
    test_random_rounds(300);
    test_full_rate_stream();
    test_random_rounds(250);
    in_valid <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0 && expected_picks.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
rtl/csbs_pkg.sv
rtl/csbs_ctrl.sv
rtl/csbs_dp.sv
rtl/channel_score_best_select.sv
tb/channel_score_best_select_test.sv
